@@ rtl/core/shc_pkg.sv @@
`timescale 1ns / 1ps
package shc_pkg;

  typedef enum logic [1:0] {
    CMD_HALL   = 2'd0,
    CMD_DUTY   = 2'd1,
    CMD_ENABLE = 2'd2,
    CMD_VEL    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_REVERSE = 2'd0,
    CFG_SCALE   = 2'd1,
    CFG_GAIN    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_OFF = 2'd0,
    PH_LOW = 2'd1,
    PH_PWM = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_MUL  = 2'd2,
    BK_OUT  = 2'd3
  } back_state_e;

  localparam int unsigned DutyWidth  = 13;
  localparam int unsigned ScaleWidth = 24;
  localparam int unsigned GainWidth  = 32;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned SpeedWidth = 32;

  // one classified event handed from front to back
  typedef struct packed {
    cmd_e                    cmd;
    logic [2:0]              sector;
    logic [CountWidth-1:0]   count;
    logic [DutyWidth-1:0]    duty;
    logic                    enable;
    logic                    pos_up;
  } event_t;

  function automatic logic [2:0] hall_to_sector(input logic [2:0] hall);
    logic [2:0] s;
    unique case (hall)
      3'd1:    s = 3'd4;
      3'd2:    s = 3'd2;
      3'd3:    s = 3'd3;
      3'd4:    s = 3'd6;
      3'd5:    s = 3'd5;
      3'd6:    s = 3'd1;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  function automatic logic [5:0] step_modes(input logic [2:0] st);
    logic [5:0] m;
    unique case (st)
      3'd1:    m = {PH_PWM, PH_LOW, PH_OFF};
      3'd2:    m = {PH_PWM, PH_OFF, PH_LOW};
      3'd3:    m = {PH_OFF, PH_PWM, PH_LOW};
      3'd4:    m = {PH_LOW, PH_PWM, PH_OFF};
      3'd5:    m = {PH_LOW, PH_OFF, PH_PWM};
      3'd6:    m = {PH_OFF, PH_LOW, PH_PWM};
      default: m = {PH_OFF, PH_OFF, PH_OFF};
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/shc_front.sv @@
`timescale 1ns / 1ps
module shc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   command_i,
  input  logic [2:0]                   hall_bits_i,
  input  logic [shc_pkg::CountWidth-1:0] timer_count_i,
  input  logic [shc_pkg::DutyWidth-1:0]  duty_command_i,
  input  logic                         enable_flag_i,
  input  logic                         reverse_i,
  output logic                         q_valid_o,
  input  logic                         q_pop_i,
  output shc_pkg::event_t              q_data_o
);

  localparam int unsigned Depth = 2;

  shc_pkg::event_t     fifo_q [Depth];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          cnt_q;
  logic [2:0]          prev_sector_q;
  shc_pkg::event_t     ev;
  logic [2:0]          sec;
  logic                push;
  logic [shc_pkg::DutyWidth-1:0] duty_neg;

  assign in_stall = (cnt_q == 2'(Depth));
  assign push     = in_valid && !in_stall;
  assign sec      = shc_pkg::hall_to_sector(hall_bits_i);

  always_comb begin
    // reversal of the most negative code saturates to the largest positive
    if (duty_command_i == {1'b1, {(shc_pkg::DutyWidth-1){1'b0}}}) begin
      duty_neg = {1'b0, {(shc_pkg::DutyWidth-1){1'b1}}};
    end else begin
      duty_neg = -duty_command_i;
    end
    ev.cmd    = shc_pkg::cmd_e'(command_i);
    ev.sector = sec;
    ev.count  = timer_count_i;
    ev.duty   = reverse_i ? duty_neg : duty_command_i;
    ev.enable = enable_flag_i;
    ev.pos_up = (sec == prev_sector_q + 3'd1) || (prev_sector_q == 3'd6 && sec == 3'd1);
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q      <= 1'b0;
      rd_ptr_q      <= 1'b0;
      cnt_q         <= 2'd0;
      prev_sector_q <= 3'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
        if (ev.cmd == shc_pkg::CMD_HALL) prev_sector_q <= sec;
      end
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = fifo_q[rd_ptr_q];

endmodule

@@ rtl/core/shc_divider.sv @@
`timescale 1ns / 1ps
module shc_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] quotient_o
);

  logic [31:0] quo_q;
  logic [16:0] rem_q;
  logic [15:0] dvs_q;
  logic [5:0]  cnt_q;
  logic [16:0] shifted;
  logic        fits;

  assign shifted = {rem_q[15:0], quo_q[31]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 6'd0;
    end else if (start_i) begin
      cnt_q <= 6'd32;
    end else if (cnt_q != 6'd0) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= 17'd0;
      dvs_q <= divisor_i;
    end else if (cnt_q != 6'd0) begin
      rem_q <= fits ? shifted - {1'b0, dvs_q} : shifted;
      quo_q <= {quo_q[30:0], fits};
    end
  end

  assign busy_o     = (cnt_q != 6'd0);
  assign quotient_o = quo_q;

endmodule

@@ rtl/core/shc_back.sv @@
`timescale 1ns / 1ps
module shc_back #(
  parameter int unsigned TIMER_WIDTH    = 16,
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  shc_pkg::event_t      q_data_i,
  input  logic [shc_pkg::ScaleWidth-1:0] scale_i,
  input  logic [shc_pkg::GainWidth-1:0]  gain_i,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           phase_a_mode_o,
  output logic [1:0]           phase_b_mode_o,
  output logic [1:0]           phase_c_mode_o,
  output logic [15:0]          compare_value_o,
  output logic [2:0]           sector_o,
  output logic [2:0]           drive_step_o,
  output logic [31:0]          rotor_position_o,
  output logic [31:0]          speed_o
);

  localparam int unsigned ProdWidth = shc_pkg::DutyWidth + shc_pkg::ScaleWidth;

  shc_pkg::back_state_e state_q, state_d;
  shc_pkg::event_t      ev_q;
  logic [2:0]           sector_q;
  logic [POSITION_WIDTH-1:0] pos_q, prev_pos_q;
  logic [15:0]          period_q;
  logic [31:0]          vel_q;
  logic [shc_pkg::DutyWidth-1:0] duty_q;
  logic                 en_q, neg_q, div_go_q;
  logic [2:0]           step_q;
  logic [ProdWidth-1:0] prod_q;
  // velocity choice: 1 take quotient, 2 force zero, 0 keep
  logic [1:0]           vel_sel_q;

  logic                 div_start, div_busy;
  logic [31:0]          div_quo;
  logic [15:0]          div_dvs;

  logic [POSITION_WIDTH-1:0] pos_n, dpos;
  logic [2:0]           sector_n, step_n;
  logic [shc_pkg::DutyWidth-1:0] duty_n;
  logic                 en_n;
  logic [shc_pkg::DutyWidth-1:0] mag;
  logic [ProdWidth-17:0] cmp_wide;
  logic [TIMER_WIDTH-1:0] cmp_sat;
  logic [31:0]          sq;
  logic [5:0]           modes;
  logic                 out_full_q;
  logic                 capture;

  shc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (gain_i),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  assign dpos = pos_q - prev_pos_q;

  // hall/duty/enable updates computed combinationally, with commutation when enabled
  always_comb begin
    sector_n = sector_q;
    pos_n    = pos_q;
    duty_n   = duty_q;
    en_n     = en_q;
    unique case (ev_q.cmd)
      shc_pkg::CMD_HALL: begin
        sector_n = ev_q.sector;
        pos_n    = ev_q.pos_up ? pos_q + 1'b1 : pos_q - 1'b1;
      end
      shc_pkg::CMD_DUTY:   duty_n = ev_q.duty;
      shc_pkg::CMD_ENABLE: en_n   = ev_q.enable;
      default: ;
    endcase
    step_n = step_q;
    if (en_n && ev_q.cmd != shc_pkg::CMD_VEL) begin
      if (!duty_n[shc_pkg::DutyWidth-1]) begin
        step_n = (sector_n == 3'd6) ? 3'd1 : sector_n + 3'd1;
      end else begin
        step_n = (sector_n < 3'd3) ? sector_n + 3'd4 : sector_n - 3'd2;
      end
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_dvs   = period_q;
    state_d   = state_q;
    q_pop_o   = 1'b0;
    capture   = 1'b0;
    unique case (state_q)
      shc_pkg::BK_IDLE: if (q_valid_i) begin
        q_pop_o = 1'b1;
        state_d = shc_pkg::BK_DIV;
      end
      shc_pkg::BK_DIV: begin
        div_start = div_go_q;
        div_dvs   = (dpos != '0) ? period_q : ev_q.count;
        state_d   = div_go_q ? shc_pkg::BK_DIV : shc_pkg::BK_MUL;
        if (!div_go_q && div_busy) state_d = shc_pkg::BK_DIV;
      end
      shc_pkg::BK_MUL: state_d = shc_pkg::BK_OUT;
      shc_pkg::BK_OUT: if (!out_full_q) begin
        capture = 1'b1;
        state_d = shc_pkg::BK_IDLE;
      end
      default: state_d = shc_pkg::BK_IDLE;
    endcase
  end

  // full 13-bit magnitude so the most negative duty gives 4096
  assign mag      = duty_q[shc_pkg::DutyWidth-1] ? -duty_q : duty_q;
  assign cmp_wide = prod_q[ProdWidth-1:16];
  assign cmp_sat  = (cmp_wide > (ProdWidth-16)'({TIMER_WIDTH{1'b1}})) ? {TIMER_WIDTH{1'b1}}
                  : TIMER_WIDTH'(cmp_wide);
  assign sq       = neg_q ? ((div_quo[31]) ? 32'h8000_0000 : -div_quo)
                          : ((div_quo[31]) ? 32'h7FFF_FFFF : div_quo);
  assign modes    = shc_pkg::step_modes(step_q);

  always_ff @(posedge clk_i) begin
    if (q_pop_o) ev_q <= q_data_i;
    prod_q <= ProdWidth'(mag) * ProdWidth'(scale_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= shc_pkg::BK_IDLE;
      sector_q   <= 3'd0;
      pos_q      <= '0;
      prev_pos_q <= '0;
      period_q   <= 16'd0;
      vel_q      <= 32'd0;
      duty_q     <= '0;
      en_q       <= 1'b0;
      neg_q      <= 1'b0;
      step_q     <= 3'd1;
      div_go_q   <= 1'b0;
      out_full_q <= 1'b0;
      phase_a_mode_o   <= 2'd0;
      phase_b_mode_o   <= 2'd0;
      phase_c_mode_o   <= 2'd0;
      compare_value_o  <= 16'd0;
      sector_o         <= 3'd0;
      drive_step_o     <= 3'd1;
      rotor_position_o <= 32'd0;
      speed_o          <= 32'd0;
    end else begin
      state_q  <= state_d;
      div_go_q <= 1'b0;
      if (state_q == shc_pkg::BK_IDLE && q_valid_i) div_go_q <= 1'b1;
      if (state_q == shc_pkg::BK_DIV && div_go_q) begin
        if (ev_q.cmd == shc_pkg::CMD_VEL) begin
          // velocity: note the direction and save the position; the divider starts every time
          if (dpos != '0) begin
            neg_q <= dpos[POSITION_WIDTH-1];
            if (period_q == 16'd0) div_go_q <= 1'b0;
          end
          prev_pos_q <= pos_q;
        end else begin
          sector_q <= sector_n;
          pos_q    <= pos_n;
          duty_q   <= duty_n;
          en_q     <= en_n;
          step_q   <= step_n;
          if (ev_q.cmd == shc_pkg::CMD_HALL) period_q <= ev_q.count;
        end
      end
      if (state_q == shc_pkg::BK_MUL && ev_q.cmd == shc_pkg::CMD_VEL) begin
        // prev_pos_q already updated, so use saved decision flags
        if (vel_sel_q == 2'd1) vel_q <= sq;
        else if (vel_sel_q == 2'd2) vel_q <= 32'd0;
      end
      if (out_full_q && !out_stall) out_full_q <= 1'b0;
      if (capture) begin
        out_full_q       <= 1'b1;
        phase_a_mode_o   <= en_q ? modes[5:4] : 2'd0;
        phase_b_mode_o   <= en_q ? modes[3:2] : 2'd0;
        phase_c_mode_o   <= en_q ? modes[1:0] : 2'd0;
        compare_value_o  <= 16'(cmp_sat);
        sector_o         <= sector_q;
        drive_step_o     <= step_q;
        rotor_position_o <= 32'(pos_q);
        speed_o          <= vel_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_sel_q <= 2'd0;
    end else if (state_q == shc_pkg::BK_DIV && div_go_q) begin
      if (dpos != '0)                     vel_sel_q <= (period_q != 16'd0) ? 2'd1 : 2'd0;
      else if (ev_q.count > period_q)     vel_sel_q <= 2'd1;
      else if (ev_q.count == 16'd0)       vel_sel_q <= 2'd2;
      else                                vel_sel_q <= 2'd0;
    end
  end

  assign out_valid = out_full_q;

endmodule

@@ rtl/core/six_step_hall_commutator_top.sv @@
`timescale 1ns / 1ps
// six-step hall commutator
// input channel in_valid/in_stall carries one event: hall edge, duty update,
// enable set or velocity tick. each event gives exactly one result on the
// out_valid/out_stall channel showing phase modes, compare value, sector,
// drive step, position and speed after that event.
// configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write only
// when idle. index 0 reverse, 1 duty scale, 2 velocity gain.
// the restoring divider in the back end runs for every event, and the back
// end handles events one at a time: it takes the next event from the queue
// only after the result of the last one has been captured.
// a two-entry queue between front and back keeps taking events while the
// back end works; when it fills, in_stall rises.
// a stalled result is held in the output register; the back end waits.
// reset sets position and speed to zero, step 1, drive disabled,
// scale 1.0, gain 0.
module six_step_hall_commutator_top #(
  parameter int unsigned TIMER_WIDTH    = 16,
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command_i,
  input  logic [2:0]  hall_bits_i,
  input  logic [15:0] timer_count_i,
  input  logic signed [12:0] duty_command_i,
  input  logic        enable_flag_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  phase_a_mode_o,
  output logic [1:0]  phase_b_mode_o,
  output logic [1:0]  phase_c_mode_o,
  output logic [15:0] compare_value_o,
  output logic [2:0]  sector_o,
  output logic [2:0]  drive_step_o,
  output logic signed [31:0] rotor_position_o,
  output logic signed [31:0] speed_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic        reverse_q;
  logic [23:0] scale_q;
  logic [31:0] gain_q;
  logic        q_valid, q_pop;
  shc_pkg::event_t q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reverse_q <= 1'b0;
      scale_q   <= 24'd65536;
      gain_q    <= 32'd0;
    end else if (cfg_valid) begin
      case (shc_pkg::cfg_idx_e'(cfg_index))
        shc_pkg::CFG_REVERSE: reverse_q <= cfg_data[0];
        shc_pkg::CFG_SCALE:   scale_q   <= cfg_data[23:0];
        shc_pkg::CFG_GAIN:    gain_q    <= cfg_data;
        default: ;
      endcase
    end
  end

  shc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command_i      (command_i),
    .hall_bits_i    (hall_bits_i),
    .timer_count_i  (timer_count_i),
    .duty_command_i (duty_command_i),
    .enable_flag_i  (enable_flag_i),
    .reverse_i      (reverse_q),
    .q_valid_o      (q_valid),
    .q_pop_i        (q_pop),
    .q_data_o       (q_data)
  );

  shc_back #(
    .TIMER_WIDTH    (TIMER_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_pop_o          (q_pop),
    .q_data_i         (q_data),
    .scale_i          (scale_q),
    .gain_i           (gain_q),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .phase_a_mode_o   (phase_a_mode_o),
    .phase_b_mode_o   (phase_b_mode_o),
    .phase_c_mode_o   (phase_c_mode_o),
    .compare_value_o  (compare_value_o),
    .sector_o         (sector_o),
    .drive_step_o     (drive_step_o),
    .rotor_position_o (rotor_position_o),
    .speed_o          (speed_o)
  );

endmodule

@@ rtl/core/shc_checker.sv @@
`timescale 1ns / 1ps
module shc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  phase_a_mode_o,
  input logic [1:0]  phase_b_mode_o,
  input logic [1:0]  phase_c_mode_o,
  input logic [2:0]  drive_step_o,
  input logic [2:0]  sector_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(drive_step_o))
    else $error("result changed under stall");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> drive_step_o != 3'd0 && drive_step_o != 3'd7)
    else $error("drive step out of range");

  a_one_pwm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> $countones({phase_a_mode_o == 2'd2, phase_b_mode_o == 2'd2,
                              phase_c_mode_o == 2'd2}) <= 1)
    else $error("more than one phase pwm");

  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> sector_o != 3'd7)
    else $error("bad sector");

endmodule

bind six_step_hall_commutator_top shc_checker u_chk (.*);

@@ dv/six_step_hall_commutator_top_test.sv @@
`timescale 1ns / 1ps
module six_step_hall_commutator_top_test;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned RANDOM_EVENTS  = 1750;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic [1:0]         pa;
    logic [1:0]         pb;
    logic [1:0]         pc;
    logic [15:0]        cmp;
    logic [2:0]         sec;
    logic [2:0]         step;
    logic signed [31:0] pos;
    logic signed [31:0] spd;
  } drive_state_t;

  typedef struct {
    shc_pkg::cmd_e      cmd;
    logic [2:0]         hall;
    logic [15:0]        count;
    logic signed [12:0] duty;
    logic               en;
    bit                 typed;
    drive_state_t       want;
  } event_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command_i = '0;
  logic [2:0] hall_bits_i = '0;
  logic [15:0] timer_count_i = '0;
  logic signed [12:0] duty_command_i = '0;
  logic enable_flag_i = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] phase_a_mode_o, phase_b_mode_o, phase_c_mode_o;
  logic [15:0] compare_value_o;
  logic [2:0] sector_o, drive_step_o;
  logic signed [31:0] rotor_position_o, speed_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  six_step_hall_commutator_top uut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  logic        m_reverse;
  logic [23:0] m_scale;
  logic [31:0] m_gain;
  logic [2:0]  m_sector, m_prev_sector, m_step;
  logic [31:0] m_pos, m_prev_pos;
  logic [15:0] m_period;
  logic signed [31:0] m_speed;
  logic signed [12:0] m_duty;
  logic m_enabled, m_negative;

  drive_state_t expected_q[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit timed_out = 1'b0;
  bit idle_mode = 1'b1;   // random gaps on both sides
  bit hold_receiver = 1'b0;

  function automatic logic [2:0] decode_hall(logic [2:0] h);
    case (h)
      3'd1: return 3'd4;
      3'd2: return 3'd2;
      3'd3: return 3'd3;
      3'd4: return 3'd6;
      3'd5: return 3'd5;
      3'd6: return 3'd1;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic signed [31:0] velocity_of(logic [31:0] divisor);
    logic [31:0] q;
    q = m_gain / divisor;
    if (m_negative) return q[31] ? 32'sh8000_0000 : -$signed(q);
    return q[31] ? 32'sh7fff_ffff : $signed(q);
  endfunction

  task automatic commutate();
    int s;
    if (!m_enabled) return;
    if (m_duty >= 0) s = m_sector + 1;
    else s = int'(m_sector) - 2;
    if (s > 6) s -= 6;
    if (s < 1) s += 6;
    m_step = s[2:0];
  endtask

  task automatic predict_drive(input event_row_t r, output drive_state_t o);
    logic [31:0] d;
    logic signed [13:0] dv;
    logic [12:0] mag;
    logic [36:0] prod;
    logic [1:0] a, b, c;
    case (r.cmd)
      shc_pkg::CMD_HALL: begin
        m_period = r.count;
        m_sector = decode_hall(r.hall);
        if (m_sector == m_prev_sector + 3'd1 || (m_prev_sector == 3'd6 && m_sector == 3'd1))
          m_pos++;
        else
          m_pos--;
        m_prev_sector = m_sector;
        commutate();
      end
      shc_pkg::CMD_DUTY: begin
        dv = r.duty;
        if (m_reverse) dv = (r.duty == -13'sd4096) ? 14'sd4095 : -dv;
        m_duty = dv[12:0];
        commutate();
      end
      shc_pkg::CMD_ENABLE: begin
        m_enabled = r.en;
        commutate();
      end
      default: begin
        d = m_pos - m_prev_pos;
        if (d != 0) begin
          m_negative = d[31];
          if (m_period > 0) m_speed = velocity_of({16'd0, m_period});
        end else if (r.count > m_period) begin
          m_speed = velocity_of({16'd0, r.count});
        end else if (r.count == 0) begin
          m_speed = '0;
        end
        m_prev_pos = m_pos;
      end
    endcase
    mag = m_duty < 0 ? -m_duty : m_duty;
    prod = mag * m_scale;
    o.cmp = (prod[36:16] > 21'hffff) ? 16'hffff : prod[31:16];
    {a, b, c} = {shc_pkg::PH_OFF, shc_pkg::PH_OFF, shc_pkg::PH_OFF};
    if (m_enabled)
      case (m_step)
        3'd1: {a, b, c} = {shc_pkg::PH_PWM, shc_pkg::PH_LOW, shc_pkg::PH_OFF};
        3'd2: {a, b, c} = {shc_pkg::PH_PWM, shc_pkg::PH_OFF, shc_pkg::PH_LOW};
        3'd3: {a, b, c} = {shc_pkg::PH_OFF, shc_pkg::PH_PWM, shc_pkg::PH_LOW};
        3'd4: {a, b, c} = {shc_pkg::PH_LOW, shc_pkg::PH_PWM, shc_pkg::PH_OFF};
        3'd5: {a, b, c} = {shc_pkg::PH_LOW, shc_pkg::PH_OFF, shc_pkg::PH_PWM};
        3'd6: {a, b, c} = {shc_pkg::PH_OFF, shc_pkg::PH_LOW, shc_pkg::PH_PWM};
        default: ;
      endcase
    o.pa = a;
    o.pb = b;
    o.pc = c;
    o.sec = m_sector;
    o.step = m_step;
    o.pos = m_pos;
    o.spd = m_speed;
  endtask

  task automatic write_register(input shc_pkg::cfg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      shc_pkg::CFG_REVERSE: m_reverse = val[0];
      shc_pkg::CFG_SCALE:   m_scale = val[23:0];
      default:              m_gain = val;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // drives one event, holds it until the transfer
  task automatic send_event(input event_row_t r);
    drive_state_t p;
    while (idle_mode && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    command_i <= r.cmd;
    hall_bits_i <= r.hall;
    timer_count_i <= r.count;
    duty_command_i <= r.duty;
    enable_flag_i <= r.en;
    do @(posedge clk_i); while (in_stall);
    predict_drive(r, p);
    if (r.typed && p != r.want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("table row disagrees with predictor: typed %h predicted %h", r.want, p);
    end
    expected_q.push_back(p);
    @(negedge clk_i);
  endtask

  function automatic event_row_t random_event();
    event_row_t r;
    r.cmd = shc_pkg::cmd_e'($urandom_range(3));
    r.hall = 3'($urandom_range(7));
    // well-formed rotation most of the time
    if ($urandom_range(99) < 70 && r.cmd == shc_pkg::CMD_HALL) begin
      case ($urandom_range(9) < 7 ? m_sector % 6 + 1 : (m_sector + 4) % 6 + 1)
        1: r.hall = 3'd6;
        2: r.hall = 3'd2;
        3: r.hall = 3'd3;
        4: r.hall = 3'd1;
        5: r.hall = 3'd5;
        default: r.hall = 3'd4;
      endcase
    end
    case ($urandom_range(3))
      0: r.count = 16'($urandom_range(3));
      1: r.count = 16'hffff - 16'($urandom_range(3));
      default: r.count = 16'($urandom);
    endcase
    r.duty = ($urandom_range(9) == 0) ? -13'sd4096 : 13'($urandom);
    r.en = ($urandom_range(4) != 0);
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic event_row_t row(shc_pkg::cmd_e c, logic [2:0] h, logic [15:0] n,
                                     logic signed [12:0] d, logic e);
    event_row_t r;
    r.cmd = c;
    r.hall = h;
    r.count = n;
    r.duty = d;
    r.en = e;
    r.typed = 1'b0;
    return r;
  endfunction

  // receiver and checker
  always @(negedge clk_i) begin
    if (hold_receiver) out_stall <= 1'b1;
    else out_stall <= idle_mode && ($urandom_range(99) < 21);
  end

  always @(posedge clk_i) begin
    drive_state_t got, want;
    if (rst_ni && out_valid && !out_stall) begin
      got = '{phase_a_mode_o, phase_b_mode_o, phase_c_mode_o, compare_value_o,
              sector_o, drive_step_o, rotor_position_o, speed_o};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected result %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    event_row_t table_rows[$];
    event_row_t r;
    int unsigned phase;

    m_reverse = 0; m_scale = 24'd65536; m_gain = 0;
    m_sector = 0; m_prev_sector = 0; m_step = 3'd1;
    m_pos = 0; m_prev_pos = 0; m_period = 0; m_speed = 0;
    m_duty = 0; m_enabled = 0; m_negative = 0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // after reset: velocity tick with zero count gives the reset state
    r = row(shc_pkg::CMD_VEL, 3'd0, 16'd0, 13'sd0, 1'b0);
    r.typed = 1'b1;
    r.want = '{shc_pkg::PH_OFF, shc_pkg::PH_OFF, shc_pkg::PH_OFF, 16'd0, 3'd0, 3'd1,
               32'sd0, 32'sd0};
    table_rows.push_back(r);
    // invalid hall code steps down
    r = row(shc_pkg::CMD_HALL, 3'd7, 16'd0, 13'sd0, 1'b0);
    r.typed = 1'b1;
    r.want = '{shc_pkg::PH_OFF, shc_pkg::PH_OFF, shc_pkg::PH_OFF, 16'd0, 3'd0, 3'd1,
               -32'sd1, 32'sd0};
    table_rows.push_back(r);
    r = row(shc_pkg::CMD_DUTY, 3'd0, 16'd0, 13'sd4095, 1'b0);
    r.typed = 1'b1;
    r.want = '{shc_pkg::PH_OFF, shc_pkg::PH_OFF, shc_pkg::PH_OFF, 16'd4095, 3'd0, 3'd1,
               -32'sd1, 32'sd0};
    table_rows.push_back(r);
    table_rows.push_back(row(shc_pkg::CMD_ENABLE, 3'd0, 16'd0, 13'sd0, 1'b1));
    for (int h = 0; h < 8; h++)
      table_rows.push_back(row(shc_pkg::CMD_HALL, 3'(h), 16'hffff, 13'sd0, 1'b1));
    table_rows.push_back(row(shc_pkg::CMD_DUTY, 3'd0, 16'd0, -13'sd4096, 1'b0));
    table_rows.push_back(row(shc_pkg::CMD_HALL, 3'd6, 16'd1, 13'sd0, 1'b0));
    table_rows.push_back(row(shc_pkg::CMD_HALL, 3'd2, 16'd100, 13'sd0, 1'b0));
    table_rows.push_back(row(shc_pkg::CMD_VEL, 3'd0, 16'd0, 13'sd0, 1'b0));
    table_rows.push_back(row(shc_pkg::CMD_VEL, 3'd0, 16'hffff, 13'sd0, 1'b0));
    table_rows.push_back(row(shc_pkg::CMD_VEL, 3'd0, 16'd5, 13'sd0, 1'b0));
    table_rows.push_back(row(shc_pkg::CMD_ENABLE, 3'd0, 16'd0, 13'sd0, 1'b0));
    table_rows.push_back(row(shc_pkg::CMD_HALL, 3'd3, 16'd0, 13'sd0, 1'b0));
    table_rows.push_back(row(shc_pkg::CMD_DUTY, 3'd0, 16'd0, 13'sd0, 1'b0));
    table_rows.push_back(row(shc_pkg::CMD_ENABLE, 3'd0, 16'd0, 13'sd0, 1'b1));
    foreach (table_rows[i]) send_event(table_rows[i]);
    in_valid <= 1'b0;
    drain_results();

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_register(shc_pkg::CFG_REVERSE, 32'd1);
          write_register(shc_pkg::CFG_SCALE, 32'hff_ffff);
          write_register(shc_pkg::CFG_GAIN, 32'hffff_ffff);
        end
        1: begin
          write_register(shc_pkg::CFG_REVERSE, 32'd0);
          write_register(shc_pkg::CFG_SCALE, 32'd0);
          write_register(shc_pkg::CFG_GAIN, 32'd0);
        end
        default: begin
          write_register(shc_pkg::CFG_REVERSE, $urandom_range(1));
          write_register(shc_pkg::CFG_SCALE, $urandom_range(24'hff_ffff));
          write_register(shc_pkg::CFG_GAIN, $urandom);
        end
      endcase
      // phase 0 runs with no gaps, phase 2 also stalls the receiver for a long stretch
      idle_mode = (phase != 0);
      for (int n = 0; n < RANDOM_EVENTS / 5; n++) begin
        if (phase == 2 && n == 20) begin
          fork
            begin
              hold_receiver = 1'b1;
              repeat (400) @(posedge clk_i);
              hold_receiver = 1'b0;
            end
          join_none
        end
        send_event(random_event());
      end
      in_valid <= 1'b0;
      drain_results();
    end

    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
